FILE: rtl/nbs_pkg.sv
// Shared types and constants of the softened gravity summation block.
package nbs_pkg;

	// Field widths fixed by the item formats.
	localparam int IDX_W       = 10;
	localparam int DATA_W      = 32;
	localparam int CNT_CFG_W   = 11;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PARTICLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GM        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EPS2      = 2'd2;

	// Opcodes of an input item.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Reset values of the configuration registers (1.0 in Q16.16).
	localparam logic [DATA_W-1:0] GM_RESET   = 32'h0001_0000;
	localparam logic [DATA_W-1:0] EPS2_RESET = 32'h0001_0000;

	// Internal arithmetic widths.
	localparam int COORD_W_MAX = 48;   // widest stored coordinate
	localparam int MAG_W       = 50;   // difference of two coordinates, with sign
	localparam int AXIS_BITS   = 39;   // an axis distance of 2^39 or more is far
	localparam int S_W         = 64;   // softened squared distance
	localparam int DVS_W       = 62;   // divisor width, below the far limit
	localparam int DVD_W       = 71;   // dividend width of the shared divider
	localparam int T_W         = 32;   // inverse square root, units of 2^-23
	localparam int ACC_W       = 64;   // exact sums

	// Input item.
	typedef struct packed {
		logic               opcode;
		logic [IDX_W-1:0]   particle_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [IDX_W-1:0]   queried_index;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] acc_z;
		logic signed [31:0] potential;
		logic               saturated;
	} out_item_t;

	// Contribution of one partner, as handed from the pair unit to the sequencer.
	typedef struct packed {
		logic                       hit;
		logic [T_W-1:0]             t;
		logic [2:0]                 q_neg;
		logic [2:0][ACC_W-1:0]      q_mag;
	} pair_res_t;

endpackage

FILE: rtl/nbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module nbs_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/nbs_divider.sv
// Restoring divider, one quotient bit per cycle.
module nbs_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nbs_pkg::DVD_W-1:0]  dividend,
	input  logic [nbs_pkg::DVS_W-1:0]  divisor,
	output logic                       done,
	output logic [nbs_pkg::DVD_W-1:0]  quotient
);

	localparam int DW = nbs_pkg::DVD_W;
	localparam int VW = nbs_pkg::DVS_W;

	logic [DW-1:0] dq_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [6:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic          ge;
	logic [VW:0]   rem_n;

	// One trial subtraction.
	always_comb begin
		rem_sh = {rem_q, dq_q[DW-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_n  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift in where the dividend bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[DW-2:0], ge};
			rem_q <= rem_n[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

FILE: rtl/nbs_isqrt.sv
// Integer square root, one result bit per cycle.
module nbs_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] val_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge;
	logic [35:0] rem_n;

	// One trial step on the next pair of bits.
	always_comb begin
		rem_sh = {rem_q, val_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_n  = ge ? (rem_sh - trial) : rem_sh;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q  <= {val_q[61:0], 2'b00};
			rem_q  <= rem_n[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/nbs_pair.sv
// Interaction unit: softened inverse distance and acceleration terms for one pair.
module nbs_pair #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] own_x,
	input  logic signed [COORD_WIDTH-1:0] own_y,
	input  logic signed [COORD_WIDTH-1:0] own_z,
	input  logic signed [COORD_WIDTH-1:0] part_x,
	input  logic signed [COORD_WIDTH-1:0] part_y,
	input  logic signed [COORD_WIDTH-1:0] part_z,
	input  logic [nbs_pkg::DATA_W-1:0]    eps2,
	output logic                          done,
	output nbs_pkg::pair_res_t            res
);

	localparam int MW = nbs_pkg::MAG_W;
	localparam int AB = nbs_pkg::AXIS_BITS;
	localparam int SW = nbs_pkg::S_W;
	localparam int DW = nbs_pkg::DVD_W;
	localparam int VW = nbs_pkg::DVS_W;
	localparam int TW = nbs_pkg::T_W;
	localparam int AW = nbs_pkg::ACC_W;

	localparam logic [3:0] E_IDLE   = 4'd0;
	localparam logic [3:0] E_SQ_MUL = 4'd1;
	localparam logic [3:0] E_SQ_ADD = 4'd2;
	localparam logic [3:0] E_CHECK  = 4'd3;
	localparam logic [3:0] E_DIV1   = 4'd4;
	localparam logic [3:0] E_SQRT   = 4'd5;
	localparam logic [3:0] E_MT_MUL = 4'd6;
	localparam logic [3:0] E_MT_ADD = 4'd7;
	localparam logic [3:0] E_MT_DIV = 4'd8;
	localparam logic [3:0] E_DONE   = 4'd9;

	logic [3:0]    state_q;
	logic [1:0]    ax_q;
	logic [AB-1:0] m_q [3];
	logic [2:0]    neg_q;
	logic [SW-1:0] s_q;
	logic [TW-1:0] t_q;
	logic [AW-1:0] q_q [3];
	logic          hit_q;
	logic [63:0]   p_lo_q;
	logic [38:0]   p_mid_q;
	logic [13:0]   p_hi_q;

	logic signed [MW-1:0] d [3];
	logic [MW-1:0]        m [3];
	logic [2:0]           far_ax;
	logic [31:0]          ml;
	logic [6:0]           mh;
	logic [77:0]          sq78;
	logic [SW-1:0]        s_fix;
	logic                 s_far;
	logic [DW-1:0]        mt;
	logic                 div_start;
	logic [DW-1:0]        div_dvd;
	logic [VW-1:0]        div_dvs;
	logic                 div_done;
	logic [DW-1:0]        div_quo;
	logic                 sq_start;
	logic                 sq_done;
	logic [31:0]          sq_root;

	// Axis differences, magnitudes and far test at the start of a pair.
	always_comb begin
		d[0] = MW'(part_x) - MW'(own_x);
		d[1] = MW'(part_y) - MW'(own_y);
		d[2] = MW'(part_z) - MW'(own_z);
		for (int k = 0; k < 3; k++) begin
			m[k]      = d[k][MW-1] ? (~d[k] + 1'b1) : d[k];
			far_ax[k] = |m[k][MW-1:AB];
		end
	end

	// Operand split of the current axis magnitude.
	assign ml = m_q[ax_q][31:0];
	assign mh = m_q[ax_q][AB-1:32];

	// Exact square of the magnitude and product of magnitude and t.
	assign sq78  = {p_hi_q, 64'd0} + {6'd0, p_mid_q, 33'd0} + {14'd0, p_lo_q};
	assign mt    = {p_mid_q[DW-33:0], 32'd0} + {7'd0, p_lo_q};
	assign s_far = |s_q[SW-1:VW];
	assign s_fix = (s_q == '0) ? SW'(1) : s_q;

	// Shared divider serves the inverse distance and all three axis quotients.
	assign div_start = ((state_q == E_CHECK) && !s_far) || (state_q == E_MT_ADD);
	assign div_dvd   = (state_q == E_CHECK) ? (DW'(1) << 62) : mt;
	assign div_dvs   = s_fix[VW-1:0];
	assign sq_start  = (state_q == E_DIV1) && div_done;

	nbs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	nbs_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (div_quo[63:0]),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			ax_q    <= '0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (start) begin
						ax_q  <= '0;
						hit_q <= 1'b0;
						state_q <= (|far_ax) ? E_DONE : E_SQ_MUL;
					end
				end
				E_SQ_MUL: begin
					state_q <= E_SQ_ADD;
				end
				E_SQ_ADD: begin
					if (ax_q == 2'd2) begin
						state_q <= E_CHECK;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= E_SQ_MUL;
					end
				end
				E_CHECK: begin
					state_q <= s_far ? E_DONE : E_DIV1;
				end
				E_DIV1: begin
					if (div_done) begin
						state_q <= E_SQRT;
					end
				end
				E_SQRT: begin
					if (sq_done) begin
						ax_q    <= '0;
						state_q <= E_MT_MUL;
					end
				end
				E_MT_MUL: begin
					state_q <= E_MT_ADD;
				end
				E_MT_ADD: begin
					state_q <= E_MT_DIV;
				end
				E_MT_DIV: begin
					if (div_done) begin
						if (ax_q == 2'd2) begin
							hit_q   <= 1'b1;
							state_q <= E_DONE;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= E_MT_MUL;
						end
					end
				end
				E_DONE: begin
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if ((state_q == E_IDLE) && start) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k]   <= m[k][AB-1:0];
				neg_q[k] <= d[k][MW-1];
			end
			s_q <= SW'(eps2);
		end
		if (state_q == E_SQ_MUL) begin
			p_lo_q  <= ml * ml;
			p_mid_q <= 39'(mh * ml);
			p_hi_q  <= 14'(mh * mh);
		end
		if (state_q == E_SQ_ADD) begin
			s_q <= s_q + SW'(sq78[77:16]);
		end
		if (state_q == E_CHECK) begin
			s_q <= s_fix;
		end
		if ((state_q == E_SQRT) && sq_done) begin
			t_q <= sq_root;
		end
		if (state_q == E_MT_MUL) begin
			p_lo_q  <= ml * t_q;
			p_mid_q <= 39'(mh * t_q);
		end
		if ((state_q == E_MT_DIV) && div_done) begin
			q_q[ax_q] <= div_quo[AW-1:0];
		end
	end

	// Result of the pair.
	assign done          = (state_q == E_DONE);
	assign res.hit       = hit_q;
	assign res.t         = t_q;
	assign res.q_neg     = neg_q;
	assign res.q_mag[0]  = q_q[0];
	assign res.q_mag[1]  = q_q[1];
	assign res.q_mag[2]  = q_q[2];

endmodule

FILE: rtl/nbody_softened_gravity_sum.sv
// Top level: particle position memory, partner walk, exact sums and output scaling.
//
// A load item (opcode 0) writes one particle's position into the position memory in the
// cycle it is accepted and leaves busy low, so loads may follow each other every cycle.
// A query item raises busy until its single result appears: for an index below
// MAX_PARTICLES the own position is read, then every slot below particles_in_use (capped
// at MAX_PARTICLES) other than the queried one is read in turn and handed to one
// interaction unit, whose shared restoring divider runs four 71-step divisions per
// partner around a 32-step square root; a far partner, with one axis out of reach or a
// softened squared distance of 2^62 or more, skips these and adds nothing. The result
// is shown for exactly one cycle with result_valid high and cannot be held off, so the
// receiver must take it then. Reading a slot that was never loaded gives undefined
// values. Configuration may only be written while busy is low.
module nbody_softened_gravity_sum #(
	parameter int MAX_PARTICLES = 1024,
	parameter int COORD_WIDTH   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  nbs_pkg::in_item_t                   item,
	output logic                                result_valid,
	output nbs_pkg::out_item_t                  result,
	input  logic                                cfg_we,
	input  logic [nbs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nbs_pkg::DATA_W-1:0]          cfg_data
);

	localparam int AW  = $clog2(MAX_PARTICLES);
	localparam int JW  = $clog2(MAX_PARTICLES + 1);
	localparam int CW  = COORD_WIDTH;
	localparam int ACW = nbs_pkg::ACC_W;

	localparam logic [2:0] T_IDLE     = 3'd0;
	localparam logic [2:0] T_OWN_RD   = 3'd1;
	localparam logic [2:0] T_OWN_CAP  = 3'd2;
	localparam logic [2:0] T_NEXT     = 3'd3;
	localparam logic [2:0] T_PART_CAP = 3'd4;
	localparam logic [2:0] T_PAIR     = 3'd5;
	localparam logic [2:0] T_SCALE    = 3'd6;
	localparam logic [2:0] T_OUT      = 3'd7;

	logic [nbs_pkg::CNT_CFG_W-1:0] piu_q;
	logic [nbs_pkg::DATA_W-1:0]    gm_q;
	logic [nbs_pkg::DATA_W-1:0]    eps_q;

	logic [2:0]                    state_q;
	logic [nbs_pkg::IDX_W-1:0]     idx_q;
	logic [JW-1:0]                 j_q;
	logic [JW-1:0]                 count_q;
	logic signed [CW-1:0]          own_x_q, own_y_q, own_z_q;
	logic signed [ACW-1:0]         acc_q [3];
	logic [ACW-1:0]                pot_q;
	logic [1:0]                    k_q;
	logic [1:0]                    ph_q;
	logic [63:0]                   hi_q;
	logic [63:0]                   lo_q;
	logic [31:0]                   out_q [4];
	logic                          sat_q;

	logic                          accept;
	logic                          in_range;
	logic [nbs_pkg::COORD_W_MAX-1:0] ext_x, ext_y, ext_z;
	logic                          mem_we;
	logic [AW-1:0]                 raddr;
	logic [3*CW-1:0]               rdata;
	logic                          eng_start;
	logic                          eng_done;
	nbs_pkg::pair_res_t            eng_res;
	logic [JW-1:0]                 count_n;
	logic [ACW-1:0]                sel_sum;
	logic                          sel_neg;
	logic [ACW-1:0]                sel_mag;
	logic [31:0]                   mul_a;
	logic [63:0]                   prod;
	logic [63:0]                   scaled;
	logic [31:0]                   clamped;
	logic                          clamp_sat;

	// Item acceptance and slot range.
	assign accept   = start && !busy;
	assign in_range = 32'(item.particle_index) < MAX_PARTICLES;

	// Stored coordinates: sign extend, keep the low COORD_WIDTH bits.
	assign ext_x = {{(nbs_pkg::COORD_W_MAX - 32){item.pos_x[31]}}, item.pos_x};
	assign ext_y = {{(nbs_pkg::COORD_W_MAX - 32){item.pos_y[31]}}, item.pos_y};
	assign ext_z = {{(nbs_pkg::COORD_W_MAX - 32){item.pos_z[31]}}, item.pos_z};
	assign mem_we = accept && (item.opcode == nbs_pkg::OP_LOAD) && in_range;

	// Read address: the partner while walking, otherwise the queried slot.
	assign raddr = (state_q == T_NEXT) ? j_q[AW-1:0] : AW'(idx_q);

	nbs_ram #(
		.WIDTH (3 * CW),
		.DEPTH (MAX_PARTICLES)
	) u_pos_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(item.particle_index)),
		.wdata ({ext_z[CW-1:0], ext_y[CW-1:0], ext_x[CW-1:0]}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign eng_start = (state_q == T_PART_CAP);

	nbs_pair #(
		.COORD_WIDTH (CW)
	) u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.own_x  (own_x_q),
		.own_y  (own_y_q),
		.own_z  (own_z_q),
		.part_x (rdata[CW-1:0]),
		.part_y (rdata[2*CW-1:CW]),
		.part_z (rdata[3*CW-1:2*CW]),
		.eps2   (eps_q),
		.done   (eng_done),
		.res    (eng_res)
	);

	// Number of partners, capped at the storage depth.
	assign count_n = (32'(piu_q) > MAX_PARTICLES) ? JW'(MAX_PARTICLES) : JW'(piu_q);

	// Output scaling: pick the sum, its sign and magnitude.
	always_comb begin
		sel_sum = (k_q == 2'd3) ? pot_q : acc_q[k_q];
		if (k_q == 2'd3) begin
			sel_neg = (pot_q != '0);
			sel_mag = pot_q;
		end else begin
			sel_neg = sel_sum[ACW-1];
			sel_mag = sel_sum[ACW-1] ? (~sel_sum + 1'b1) : sel_sum;
		end
		mul_a = (ph_q == 2'd0) ? sel_mag[63:32] : sel_mag[31:0];
		prod  = mul_a * gm_q;
	end

	// Magnitude times GM, shifted right by 23 (2^40 if hi_q reaches 2^40), then clamped.
	always_comb begin
		if (|hi_q[63:40]) begin
			scaled = 64'd1 << 40;
		end else begin
			scaled = {hi_q[54:0], 9'd0} + {23'd0, lo_q[63:23]};
		end
		clamp_sat = 1'b0;
		if (!sel_neg) begin
			if (scaled > 64'h7fff_ffff) begin
				clamp_sat = 1'b1;
				clamped   = 32'h7fff_ffff;
			end else begin
				clamped = scaled[31:0];
			end
		end else begin
			if (scaled > 64'h8000_0000) begin
				clamp_sat = 1'b1;
				clamped   = 32'h8000_0000;
			end else begin
				clamped = ~scaled[31:0] + 32'd1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= '0;
			gm_q  <= nbs_pkg::GM_RESET;
			eps_q <= nbs_pkg::EPS2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nbs_pkg::CFG_PARTICLES: piu_q <= cfg_data[nbs_pkg::CNT_CFG_W-1:0];
				nbs_pkg::CFG_GM:        gm_q  <= cfg_data;
				nbs_pkg::CFG_EPS2:      eps_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Query sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			j_q     <= '0;
			k_q     <= '0;
			ph_q    <= '0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept && (item.opcode == nbs_pkg::OP_QUERY)) begin
						k_q     <= '0;
						ph_q    <= '0;
						state_q <= in_range ? T_OWN_RD : T_SCALE;
					end
				end
				T_OWN_RD: begin
					state_q <= T_OWN_CAP;
				end
				T_OWN_CAP: begin
					j_q     <= '0;
					state_q <= T_NEXT;
				end
				T_NEXT: begin
					if (j_q >= count_q) begin
						state_q <= T_SCALE;
					end else if (32'(j_q) == 32'(idx_q)) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= T_PART_CAP;
					end
				end
				T_PART_CAP: begin
					state_q <= T_PAIR;
				end
				T_PAIR: begin
					if (eng_done) begin
						j_q     <= j_q + 1'b1;
						state_q <= T_NEXT;
					end
				end
				T_SCALE: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (k_q == 2'd3) begin
							state_q <= T_OUT;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				T_OUT: begin
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// Query datapath: own position, sums and scaled outputs.
	always_ff @(posedge clk) begin
		if ((state_q == T_IDLE) && accept) begin
			idx_q   <= item.particle_index;
			count_q <= count_n;
			pot_q   <= '0;
			sat_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= '0;
			end
		end
		if (state_q == T_OWN_CAP) begin
			own_x_q <= rdata[CW-1:0];
			own_y_q <= rdata[2*CW-1:CW];
			own_z_q <= rdata[3*CW-1:2*CW];
		end
		if ((state_q == T_PAIR) && eng_done && eng_res.hit) begin
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= eng_res.q_neg[k] ? (acc_q[k] - eng_res.q_mag[k])
				                             : (acc_q[k] + eng_res.q_mag[k]);
			end
			pot_q <= pot_q + ACW'(eng_res.t);
		end
		if (state_q == T_SCALE) begin
			if (ph_q == 2'd0) begin
				hi_q <= prod;
			end
			if (ph_q == 2'd1) begin
				lo_q <= prod;
			end
			if (ph_q == 2'd2) begin
				out_q[k_q] <= clamped;
				sat_q      <= sat_q | clamp_sat;
			end
		end
	end

	// Ports.
	assign busy                 = (state_q != T_IDLE);
	assign result_valid         = (state_q == T_OUT);
	assign result.queried_index = idx_q;
	assign result.acc_x         = out_q[0];
	assign result.acc_y         = out_q[1];
	assign result.acc_z         = out_q[2];
	assign result.potential     = out_q[3];
	assign result.saturated     = sat_q;

	// The result strobe lasts one cycle and the block goes idle after it.
	a_one_cycle_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid && !busy)
		else $error("result strobe held for more than one cycle");

	// A partner is handed to the interaction unit only while it is idle.
	a_pair_idle: assert property (@(posedge clk) disable iff (!arst_n)
		eng_start |-> (u_pair.state_q == 4'd0))
		else $error("interaction unit started while busy");

	// An accepted query makes the block busy in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.opcode == nbs_pkg::OP_QUERY)) |=> busy)
		else $error("query accepted without becoming busy");

	// The partner walk never runs past the partner count and skips the queried slot.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_PART_CAP) |-> (j_q < count_q) && (32'(j_q) != 32'(idx_q)))
		else $error("partner index out of range or equal to queried slot");

endmodule
